// File: hdl/button_action_rule_table_macros.svh
// assertion macros for the button action rule table
`ifndef BUTTON_ACTION_RULE_TABLE_MACROS_SVH
`define BUTTON_ACTION_RULE_TABLE_MACROS_SVH
`ifndef SYNTH
`define BART_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BART_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BART_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BART_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/bart_pkg.sv
`timescale 1ns / 1ps
package bart_pkg;
	typedef enum logic [2:0] {
		CMD_EVENT = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_SET   = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ON    = 3'd0,
		KIND_OFF   = 3'd1,
		KIND_TOG   = 3'd2,
		KIND_REPLY = 3'd3,
		KIND_DONE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ACT_ON  = 2'd0,
		ACT_OFF = 2'd1,
		ACT_TOG = 2'd2,
		ACT_NONE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		TRIG_SHORT_DBL = 2'd0,
		TRIG_SHORT     = 2'd1,
		TRIG_LONG      = 2'd2,
		TRIG_DBL       = 2'd3
	} trig_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_EVAL = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

	localparam logic [15:0] DEFAULT_MARKER = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  sender;
		logic [7:0]  out;
		logic [3:0]  button;
		logic [1:0]  trig;
		logic [1:0]  act;
		logic [15:0] timer;
		logic [7:0]  cmask;
		logic [7:0]  cstates;
	} rule_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  sender_id;
		logic [7:0]  force_src_id;
		logic [15:0] short_mask;
		logic [15:0] long_mask;
		logic [15:0] double_mask;
		logic [7:0]  output_state;
		logic [3:0]  button_num;
		logic [1:0]  trigger_kind;
		logic [1:0]  action_kind;
		logic [7:0]  out_num;
		logic [15:0] timer_value;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  out_sel;
		logic [15:0] timer_out;
		logic        last;
	} out_word_t;
endpackage

// File: hdl/bart_in_if.sv
`timescale 1ns / 1ps
interface bart_in_if;
	logic valid;
	logic ready;
	bart_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/bart_out_if.sv
`timescale 1ns / 1ps
interface bart_out_if;
	logic valid;
	logic ready;
	bart_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/button_action_rule_table.sv
`timescale 1ns / 1ps
`include "button_action_rule_table_macros.svh"
// Button action rule table. One word in, a run of result words out, the final one
// with last set. Rules sit in a one-port synchronous RAM with a registered read;
// a button event walks the rules from newest to oldest, reading and then comparing
// each rule. A hit with an action other than none hands its result word to the
// output register in the compare cycle and holds the walk there while the output
// stalls; a hit on a rule with an out-of-range output cuts the walk short.
// All other commands give their single word the cycle after acceptance, and the
// next word can be taken once that word leaves. Default timers live in flip-flops.
module button_action_rule_table #(
	parameter int TABLE_DEPTH = 32,
	parameter int NUM_OUTPUTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	bart_in_if.sink  in_ch,
	bart_out_if.source out_ch
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

	bart_pkg::rule_t rule_mem [TABLE_DEPTH];
	bart_pkg::rule_t rd_s1;
	logic [15:0] dflt_q [NUM_OUTPUTS];
	logic [CW-1:0] used_q, idx_q;
	bart_pkg::state_t state_q, state_d;
	bart_pkg::in_word_t req_q;
	logic [7:0] match_q;
	logic out_v_q;
	bart_pkg::out_word_t out_q;

	logic accept, out_free, hit, bad, emit, load_out;
	logic [15:0] bits, trig_bits;
	logic [15:0] tmr;
	logic [AW-1:0] rd_addr;
	bart_pkg::rule_t new_rule;
	bart_pkg::out_word_t res, out_d;

	assign out_free = !out_v_q || out_ch.ready;
	assign in_ch.ready = (state_q == bart_pkg::ST_IDLE) && out_free;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
	assign rd_addr = AW'(idx_q - CW'(1));

	always_comb begin
		new_rule.sender  = in_ch.data.sender_id;
		new_rule.out     = in_ch.data.out_num;
		new_rule.button  = in_ch.data.button_num;
		new_rule.trig    = in_ch.data.trigger_kind;
		new_rule.act     = in_ch.data.action_kind;
		new_rule.timer   = in_ch.data.timer_value;
		new_rule.cmask   = in_ch.data.short_mask[7:0];
		new_rule.cstates = in_ch.data.output_state;
	end

	// read data holds while a hit waits for the output
	always_ff @(posedge clk) begin
		if (accept && in_ch.data.cmd == bart_pkg::CMD_ADD && used_q < CW'(TABLE_DEPTH))
			rule_mem[AW'(used_q)] <= new_rule;
		if (state_q == bart_pkg::ST_READ && idx_q != '0)
			rd_s1 <= rule_mem[rd_addr];
	end

	always_comb begin
		unique case (bart_pkg::trig_t'(rd_s1.trig))
			bart_pkg::TRIG_SHORT_DBL: trig_bits = req_q.short_mask | req_q.double_mask;
			bart_pkg::TRIG_SHORT:     trig_bits = req_q.short_mask;
			bart_pkg::TRIG_LONG:      trig_bits = req_q.long_mask;
			default:                  trig_bits = req_q.double_mask;
		endcase
		bits = trig_bits >> rd_s1.button;
		hit = (rd_s1.sender == match_q) && bits[0]
			&& ((req_q.output_state & rd_s1.cmask) == rd_s1.cstates);
		bad = rd_s1.out >= 8'(NUM_OUTPUTS);
		tmr = (rd_s1.timer == bart_pkg::DEFAULT_MARKER) ? dflt_q[OW'(rd_s1.out)]
			: rd_s1.timer;
		emit = hit && !bad && (rd_s1.act != bart_pkg::ACT_NONE);
		res.last = 1'b0;
		res.out_sel = rd_s1.out;
		unique case (bart_pkg::act_t'(rd_s1.act))
			bart_pkg::ACT_ON:  begin res.kind = bart_pkg::KIND_ON;  res.timer_out = tmr; end
			bart_pkg::ACT_OFF: begin res.kind = bart_pkg::KIND_OFF; res.timer_out = '0; end
			default:           begin res.kind = bart_pkg::KIND_TOG; res.timer_out = tmr; end
		endcase
	end

	// output word load
	always_comb begin
		load_out = 1'b0;
		out_d = '{kind: bart_pkg::KIND_DONE, out_sel: '0, timer_out: '0, last: 1'b1};
		if (accept) begin
			load_out = (in_ch.data.cmd != bart_pkg::CMD_EVENT);
			if (in_ch.data.cmd == bart_pkg::CMD_READ && in_ch.data.out_num < 8'(NUM_OUTPUTS))
				out_d = '{kind: bart_pkg::KIND_REPLY, out_sel: in_ch.data.out_num,
					timer_out: dflt_q[OW'(in_ch.data.out_num)], last: 1'b1};
		end else if (state_q == bart_pkg::ST_EVAL && emit && out_free) begin
			load_out = 1'b1;
			out_d = res;
		end else if (state_q == bart_pkg::ST_OUT && out_free) begin
			load_out = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bart_pkg::ST_IDLE:
				if (accept && in_ch.data.cmd == bart_pkg::CMD_EVENT) state_d = bart_pkg::ST_READ;
			bart_pkg::ST_READ:
				if (idx_q == '0) state_d = bart_pkg::ST_OUT;
				else state_d = bart_pkg::ST_EVAL;
			bart_pkg::ST_EVAL:
				if (hit && bad) state_d = bart_pkg::ST_OUT;
				else if (!emit) state_d = bart_pkg::ST_READ;
				else if (out_free) state_d = bart_pkg::ST_READ;
			default:
				if (out_free) state_d = bart_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bart_pkg::ST_IDLE;
			used_q <= '0;
			idx_q <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < NUM_OUTPUTS; i++) dflt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_v_q <= 1'b1;
				out_q <= out_d;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (accept) begin
				req_q <= in_ch.data;
				match_q <= (in_ch.data.force_src_id != '0) ? in_ch.data.force_src_id
					: in_ch.data.sender_id;
				idx_q <= used_q;
				unique case (in_ch.data.cmd)
					bart_pkg::CMD_ADD:
						if (used_q < CW'(TABLE_DEPTH)) used_q <= used_q + CW'(1);
					bart_pkg::CMD_CLEAR:
						used_q <= '0;
					bart_pkg::CMD_SET:
						if (in_ch.data.out_num < 8'(NUM_OUTPUTS))
							dflt_q[OW'(in_ch.data.out_num)] <= in_ch.data.timer_value;
					default: ;
				endcase
			end else if (state_q == bart_pkg::ST_READ && idx_q != '0) begin
				idx_q <= idx_q - CW'(1);
			end
		end
	end

	`BART_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= CW'(TABLE_DEPTH))
	`BART_ASSERT_IMP(a_idx_bound, clk, arst_n, state_q != bart_pkg::ST_IDLE, idx_q <= used_q)
	`BART_ASSERT_IMP(a_busy_noacc, clk, arst_n, state_q != bart_pkg::ST_IDLE, !in_ch.ready)
	`BART_ASSERT_NXT(a_done_idle, clk, arst_n,
		state_q == bart_pkg::ST_OUT && out_free, out_v_q && out_q.last)
endmodule

// File: tb/sv/tb_button_action_rule_table.sv
`timescale 1ns / 1ps
module tb_button_action_rule_table;
	localparam int DEPTH = 32;
	localparam int OUTS = 8;

	logic clk;
	logic arst_n;

	bart_in_if in_ch();
	bart_out_if out_ch();

	button_action_rule_table #(.TABLE_DEPTH(DEPTH), .NUM_OUTPUTS(OUTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	bart_pkg::in_word_t pending_words[$];
	bart_pkg::out_word_t expected_words[$];
	int errors = 0;
	int words_sent = 0;
	bit stim_done = 0;
	bit in_acc = 0;

	// predictor's copy of the block state
	bart_pkg::rule_t rules[DEPTH];
	int rules_used = 0;
	logic [15:0] dflt_timer[OUTS];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input bart_pkg::out_word_t got,
			input bart_pkg::out_word_t want);
		errors++;
		$display("mismatch %s: got kind=%0d sel=%0d tmr=%0d last=%0d %s",
			what, got.kind, got.out_sel, got.timer_out, got.last,
			$sformatf("want kind=%0d sel=%0d tmr=%0d last=%0d",
				want.kind, want.out_sel, want.timer_out, want.last));
	endtask

	function automatic void push_result(input bart_pkg::kind_t k, input logic [7:0] sel,
			input logic [15:0] tmr, input logic lst);
		bart_pkg::out_word_t w;
		w.kind = k;
		w.out_sel = sel;
		w.timer_out = tmr;
		w.last = lst;
		expected_words.push_back(w);
	endfunction

	function automatic bit trigger_match(input bart_pkg::rule_t r, input bart_pkg::in_word_t w);
		logic [15:0] bitsel;
		bitsel = 16'd1 << r.button;
		case (bart_pkg::trig_t'(r.trig))
			bart_pkg::TRIG_SHORT_DBL: return |((w.short_mask | w.double_mask) & bitsel);
			bart_pkg::TRIG_SHORT: return |(w.short_mask & bitsel);
			bart_pkg::TRIG_LONG: return |(w.long_mask & bitsel);
			default: return |(w.double_mask & bitsel);
		endcase
	endfunction

	function automatic void predict_word(input bart_pkg::in_word_t w);
		logic [7:0] src;
		logic [15:0] tmr;
		bart_pkg::rule_t r;
		case (w.cmd)
			bart_pkg::CMD_EVENT: begin
				src = (w.force_src_id != 0) ? w.force_src_id : w.sender_id;
				for (int i = rules_used - 1; i >= 0; i--) begin
					r = rules[i];
					if (r.sender != src || !trigger_match(r, w)
							|| (w.output_state & r.cmask) != r.cstates)
						continue;
					if (r.out >= OUTS)
						break;
					tmr = (r.timer == bart_pkg::DEFAULT_MARKER) ? dflt_timer[r.out[2:0]]
						: r.timer;
					case (bart_pkg::act_t'(r.act))
						bart_pkg::ACT_ON: push_result(bart_pkg::KIND_ON, r.out, tmr, 1'b0);
						bart_pkg::ACT_OFF: push_result(bart_pkg::KIND_OFF, r.out, 16'd0, 1'b0);
						bart_pkg::ACT_TOG: push_result(bart_pkg::KIND_TOG, r.out, tmr, 1'b0);
						default: ;
					endcase
				end
			end
			bart_pkg::CMD_ADD: if (rules_used < DEPTH) begin
				r.sender = w.sender_id;
				r.cmask = w.short_mask[7:0];
				r.cstates = w.output_state;
				r.button = w.button_num;
				r.trig = w.trigger_kind;
				r.act = w.action_kind;
				r.out = w.out_num;
				r.timer = w.timer_value;
				rules[rules_used] = r;
				rules_used++;
			end
			bart_pkg::CMD_CLEAR: rules_used = 0;
			bart_pkg::CMD_SET: if (w.out_num < OUTS)
				dflt_timer[w.out_num[2:0]] = w.timer_value;
			bart_pkg::CMD_READ: if (w.out_num < OUTS) begin
				push_result(bart_pkg::KIND_REPLY, w.out_num, dflt_timer[w.out_num[2:0]], 1'b1);
				return;
			end
			default: ;
		endcase
		push_result(bart_pkg::KIND_DONE, 8'd0, 16'd0, 1'b1);
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bart_pkg::in_word_t random_word();
		bart_pkg::in_word_t w;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(bart_pkg::in_word_t)-1:0];
		return w;
	endfunction

	// rule with small sender/button space so events hit often
	function automatic bart_pkg::in_word_t rule_word();
		bart_pkg::in_word_t w;
		w = random_word();
		w.cmd = bart_pkg::CMD_ADD;
		w.sender_id = 8'($urandom_range(1, 3));
		w.button_num = 4'($urandom_range(0, 3));
		w.short_mask[7:0] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
		w.output_state = w.short_mask[7:0] & 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			w.output_state = 8'($urandom);
		w.out_num = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		if ($urandom_range(0, 2) == 0)
			w.timer_value = bart_pkg::DEFAULT_MARKER;
		return w;
	endfunction

	function automatic bart_pkg::in_word_t event_word();
		bart_pkg::in_word_t w;
		w = random_word();
		w.cmd = bart_pkg::CMD_EVENT;
		w.sender_id = 8'($urandom_range(0, 3));
		w.force_src_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'd0;
		if ($urandom_range(0, 1) == 0) begin
			w.short_mask[15:4] = '0;
			w.long_mask[15:4] = '0;
			w.double_mask[15:4] = '0;
		end
		return w;
	endfunction

	// driver
	int in_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (in_ch.valid && !in_acc) begin
		end else if (in_gap > 0) begin
			in_gap--;
			in_ch.valid <= 1'b0;
		end else if (pending_words.size() > 0) begin
			in_ch.data <= pending_words.pop_front();
			in_ch.valid <= 1'b1;
			in_gap = pick_gap();
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// acceptance: sample at the rising edge, predict
	always @(posedge clk) begin
		in_acc = arst_n && in_ch.valid && in_ch.ready;
		if (in_acc) begin
			predict_word(in_ch.data);
			words_sent++;
		end
	end

	int out_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			out_gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		bart_pkg::out_word_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_words.size() == 0) begin
				report("unexpected word", got, '0);
			end else begin
				want = expected_words.pop_front();
				if (got.kind != want.kind) report("kind", got, want);
				else if (got.out_sel != want.out_sel) report("out_sel", got, want);
				else if (got.timer_out != want.timer_out) report("timer_out", got, want);
				else if (got.last != want.last) report("last", got, want);
			end
		end
	end

	// directed part then random part
	initial begin
		bart_pkg::in_word_t w;
		int queued;
		foreach (dflt_timer[i]) dflt_timer[i] = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		w = '0;
		w.cmd = bart_pkg::CMD_READ; w.out_num = 8'd0; pending_words.push_back(w);
		w.cmd = bart_pkg::CMD_SET; w.out_num = 8'd7; w.timer_value = 16'hFFFF;
		pending_words.push_back(w);
		w.cmd = bart_pkg::CMD_SET; w.out_num = 8'd0; w.timer_value = 16'h1234;
		pending_words.push_back(w);
		w.cmd = bart_pkg::CMD_SET; w.out_num = 8'd8; w.timer_value = 16'h5555;
		pending_words.push_back(w);
		w.cmd = bart_pkg::CMD_READ; w.out_num = 8'd7; pending_words.push_back(w);
		w.cmd = bart_pkg::CMD_READ; w.out_num = 8'd255; pending_words.push_back(w);
		w = '0; w.sender_id = 8'hFF; pending_words.push_back(w);
		for (int a = 0; a < 4; a++) begin
			w = '0;
			w.cmd = bart_pkg::CMD_ADD; w.sender_id = 8'd5; w.button_num = 4'd15;
			w.trigger_kind = a[1:0]; w.action_kind = a[1:0];
			w.out_num = (a == 3) ? 8'd0 : 8'd7;
			w.timer_value = (a == 2) ? bart_pkg::DEFAULT_MARKER : 16'(100 + a);
			pending_words.push_back(w);
		end
		w = '0; w.cmd = bart_pkg::CMD_EVENT; w.sender_id = 8'd5;
		w.short_mask = 16'h8000; w.long_mask = 16'hFFFF; w.double_mask = 16'h8000;
		w.output_state = 8'hFF;
		pending_words.push_back(w);
		w.sender_id = 8'd9; w.force_src_id = 8'd5; pending_words.push_back(w);
		// rule with an out-of-range output aborts older rules
		w = '0; w.cmd = bart_pkg::CMD_ADD; w.sender_id = 8'd5; w.button_num = 4'd15;
		w.trigger_kind = bart_pkg::TRIG_LONG; w.out_num = 8'd200; w.short_mask = 16'h00F0;
		w.output_state = 8'hA0;
		pending_words.push_back(w);
		w = '0; w.cmd = bart_pkg::CMD_EVENT; w.sender_id = 8'd5; w.long_mask = 16'h8000;
		w.short_mask = 16'h8000; w.output_state = 8'hA5; pending_words.push_back(w);
		w.output_state = 8'h50; pending_words.push_back(w);
		w = '0; w.cmd = 3'd7; pending_words.push_back(w);
		w.cmd = 3'd5; pending_words.push_back(w);
		// fill the table past full
		for (int i = 0; i < 30; i++) begin
			w = rule_word();
			pending_words.push_back(w);
		end
		w = '0; w.cmd = bart_pkg::CMD_EVENT; w.sender_id = 8'd5; w.short_mask = 16'hFFFF;
		w.long_mask = 16'hFFFF; w.double_mask = 16'hFFFF; w.output_state = 8'hFF;
		pending_words.push_back(w);
		w = '0; w.cmd = bart_pkg::CMD_CLEAR; pending_words.push_back(w);
		w = '0; w.cmd = bart_pkg::CMD_EVENT; w.sender_id = 8'd5; w.short_mask = 16'hFFFF;
		pending_words.push_back(w);

		queued = 0;
		while (queued < 80) begin
			int p;
			p = $urandom_range(0, 99);
			if (p < 35) w = rule_word();
			else if (p < 75) w = event_word();
			else if (p < 82) begin
				w = random_word(); w.cmd = bart_pkg::CMD_SET;
				if ($urandom_range(0, 3) != 0) w.out_num = 8'($urandom_range(0, 7));
			end else if (p < 88) begin
				w = random_word(); w.cmd = bart_pkg::CMD_READ;
				if ($urandom_range(0, 3) != 0) w.out_num = 8'($urandom_range(0, 7));
			end else if (p < 92) begin
				w = random_word(); w.cmd = bart_pkg::CMD_CLEAR;
			end else begin
				w = random_word();
			end
			pending_words.push_back(w);
			queued++;
		end

		wait (pending_words.size() == 0 && !in_ch.valid);
		wait (expected_words.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("** button_action_rule_table: PASSED **");
		else
			$display("** button_action_rule_table: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** button_action_rule_table: FAILED **");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hdl
hdl/bart_pkg.sv
hdl/bart_in_if.sv
hdl/bart_out_if.sv
hdl/button_action_rule_table.sv
tb/sv/tb_button_action_rule_table.sv
